// ----- rtl/dalf_pkg.sv -----
// types, constants and register indexes shared by the door ambient led fader
// no dependencies
`default_nettype none

package dalf_pkg;

    // elapsed counter width default
    localparam int TIMER_BITS_DEF = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_STEP_MS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_STEP_MS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_MAX     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_MIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_MIN       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_OFF_LEVEL = 3'd5;

    // elapsed counter slots
    localparam int TMR_WHITE_UP   = 0;
    localparam int TMR_WHITE_DOWN = 1;
    localparam int TMR_RED_UP     = 2;
    localparam int TMR_RED_DOWN   = 3;
    localparam int TMR_NUM        = 4;

    typedef enum logic [2:0] {
        MODE_ALL_OFF       = 3'd0,
        MODE_WHITE_UP      = 3'd1,
        MODE_WHITE_DOWN    = 3'd2,
        MODE_RED_UP        = 3'd3,
        MODE_RED_DOWN      = 3'd4,
        MODE_RED_JUMP_UP   = 3'd5,
        MODE_RED_JUMP_DOWN = 3'd6,
        MODE_RED_JUMP_OFF  = 3'd7
    } t_mode;

    typedef enum logic [1:0] {
        COLOR_OFF   = 2'd0,
        COLOR_WHITE = 2'd1,
        COLOR_RED   = 2'd2
    } t_color;

    typedef struct packed {
        logic       door_open;
        logic [7:0] light_level;
    } t_in_item;

    typedef struct packed {
        logic [7:0] white_led_level;
        logic [1:0] pixel_color;
        logic [7:0] pixel_brightness;
        logic       pixel_refresh;
        logic [2:0] active_mode;
    } t_out_item;

endpackage

`default_nettype wire

// ----- rtl/door_ambient_led_fader.sv -----
// door ambient led fader: one millisecond tick per beat in, one result beat out
// depends on dalf_pkg
//
// beat path: input register, then result register; throughput: one beat per cycle while
// not stalled; the mode choice and mode step for a tick are one short combinational pass
// from the input register into the state and result registers
// reset: synchronous, active low; clears mode, levels, counters and config to defaults
`default_nettype none

module door_ambient_led_fader
    import dalf_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write port
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // tick input channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_item              i_in_data,
    // result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_item                  o_out_data
);

    // compare width covers both the counters and the 16 bit step registers
    localparam int CMP_W = (TIMER_BITS > CFG_DATA_W) ? TIMER_BITS : CFG_DATA_W;

    // configuration registers
    logic [15:0] r_white_step_ms;
    logic [15:0] r_red_step_ms;
    logic [7:0]  r_white_max;
    logic [7:0]  r_white_min;
    logic [7:0]  r_red_min;
    logic [7:0]  r_red_off_level;

    // input register
    logic        r_in_valid;
    t_in_item    r_in;

    // block state
    t_mode                 r_mode,        n_mode;
    logic [7:0]            r_white_level, n_white_level;
    logic [7:0]            r_red_level,   n_red_level;
    logic [7:0]            r_red_target,  n_red_target;
    logic                  r_red_reached, n_red_reached;
    logic [TIMER_BITS-1:0] r_elapsed [TMR_NUM];
    logic [TIMER_BITS-1:0] n_elapsed [TMR_NUM];
    logic [7:0]            r_white_out,   n_white_out;
    t_color                r_pix_color,   n_pix_color;
    logic [7:0]            r_pix_bright,  n_pix_bright;

    // result register
    logic        r_out_valid;
    t_out_item   r_out, n_out;

    logic        w_out_free;
    logic        w_fire;
    logic        w_in_accept;
    logic        w_refresh;

    // handshake: a tick is worked on when the result register can take it
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_fire      = r_in_valid && w_out_free;
    assign o_in_stall  = r_in_valid && !w_out_free;
    assign w_in_accept = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_white_step_ms <= 16'd4;
            r_red_step_ms   <= 16'd8;
            r_white_max     <= 8'd255;
            r_white_min     <= 8'd0;
            r_red_min       <= 8'd1;
            r_red_off_level <= 8'd0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_WHITE_STEP_MS: r_white_step_ms <= i_cfg_data;
                CFG_RED_STEP_MS:   r_red_step_ms   <= i_cfg_data;
                CFG_WHITE_MAX:     r_white_max     <= i_cfg_data[7:0];
                CFG_WHITE_MIN:     r_white_min     <= i_cfg_data[7:0];
                CFG_RED_MIN:       r_red_min       <= i_cfg_data[7:0];
                CFG_RED_OFF_LEVEL: r_red_off_level <= i_cfg_data[7:0];
                default: ;  // indexes past the list are ignored
            endcase
        end
    end

    // one tick: counters, mode choice, then one step of the chosen mode
    always_comb begin
        n_mode        = r_mode;
        n_white_level = r_white_level;
        n_red_level   = r_red_level;
        n_red_target  = r_red_target;
        n_red_reached = r_red_reached;
        n_white_out   = r_white_out;
        n_pix_color   = r_pix_color;
        n_pix_bright  = r_pix_bright;
        w_refresh     = 1'b0;
        for (int i = 0; i < TMR_NUM; i++) begin
            n_elapsed[i] = r_elapsed[i];
        end

        if (w_fire) begin
            // free-running counters, saturating at all ones
            for (int i = 0; i < TMR_NUM; i++) begin
                if (r_elapsed[i] != {TIMER_BITS{1'b1}}) begin
                    n_elapsed[i] = r_elapsed[i] + TIMER_BITS'(1);
                end
            end

            // mode choice
            if (!r_in.door_open && r_in.light_level == 8'd0
                && r_white_level == r_white_min && r_red_level == r_red_off_level) begin
                n_mode = MODE_ALL_OFF;
            end else if (r_in.door_open) begin
                // red goes off at once, otherwise white fades in
                if (r_red_level > r_red_off_level) begin
                    n_mode = MODE_RED_JUMP_OFF;
                end else if (r_white_level < r_white_max) begin
                    n_mode = MODE_WHITE_UP;
                end
            end else begin
                n_red_target = r_in.light_level;
                if (r_white_level > r_white_min) begin
                    n_mode = MODE_WHITE_DOWN;
                end else if (n_red_target >= r_red_min) begin
                    // slow ramp only the first time, later changes jump
                    if (r_red_level < n_red_target) begin
                        n_mode = r_red_reached ? MODE_RED_JUMP_UP : MODE_RED_UP;
                    end else if (r_red_level > n_red_target) begin
                        n_mode = MODE_RED_JUMP_DOWN;
                    end
                end else if (n_red_target == 8'd0 && r_red_level > r_red_off_level) begin
                    n_mode = MODE_RED_DOWN;
                end
            end

            // mode step
            case (n_mode)
                MODE_ALL_OFF: begin
                    n_white_level = 8'd0;
                    n_red_level   = 8'd0;
                end
                MODE_WHITE_UP: begin
                    if (CMP_W'(n_elapsed[TMR_WHITE_UP]) >= CMP_W'(r_white_step_ms)) begin
                        n_elapsed[TMR_WHITE_UP] = '0;
                        if (r_white_level < r_white_max) begin
                            n_white_level = r_white_level + 8'd1;
                        end
                        n_red_reached = 1'b0;
                        n_pix_color   = COLOR_WHITE;
                        n_pix_bright  = n_white_level;
                        n_white_out   = n_white_level;
                        w_refresh     = 1'b1;
                    end
                end
                MODE_WHITE_DOWN: begin
                    if (CMP_W'(n_elapsed[TMR_WHITE_DOWN]) >= CMP_W'(r_white_step_ms)) begin
                        n_elapsed[TMR_WHITE_DOWN] = '0;
                        if (r_white_level > r_white_min) begin
                            n_white_level = r_white_level - 8'd1;
                        end
                        n_pix_color  = COLOR_WHITE;
                        n_pix_bright = n_white_level;
                        n_white_out  = n_white_level;
                        w_refresh    = 1'b1;
                    end
                end
                MODE_RED_UP: begin
                    if (CMP_W'(n_elapsed[TMR_RED_UP]) >= CMP_W'(r_red_step_ms)) begin
                        n_elapsed[TMR_RED_UP] = '0;
                        if (r_red_level < n_red_target) begin
                            n_red_level = r_red_level + 8'd1;
                            if (n_red_level == n_red_target) begin
                                n_red_reached = 1'b1;
                            end
                        end
                        n_pix_color  = COLOR_RED;
                        n_pix_bright = n_red_level;
                        w_refresh    = 1'b1;
                    end
                end
                MODE_RED_DOWN: begin
                    if (CMP_W'(n_elapsed[TMR_RED_DOWN]) >= CMP_W'(r_red_step_ms)) begin
                        n_elapsed[TMR_RED_DOWN] = '0;
                        if (r_red_level > r_red_off_level) begin
                            n_red_level = r_red_level - 8'd1;
                            if (n_red_level == r_red_off_level) begin
                                n_red_reached = 1'b0;
                            end
                        end
                        n_pix_color  = COLOR_RED;
                        n_pix_bright = n_red_level;
                        w_refresh    = 1'b1;
                    end
                end
                MODE_RED_JUMP_UP: begin
                    if (r_red_level < n_red_target) begin
                        n_red_level  = n_red_target;
                        n_pix_color  = COLOR_RED;
                        n_pix_bright = n_red_target;
                        w_refresh    = 1'b1;
                    end
                end
                MODE_RED_JUMP_DOWN: begin
                    if (r_red_level > n_red_target) begin
                        n_red_level  = n_red_target;
                        n_pix_color  = COLOR_RED;
                        n_pix_bright = n_red_target;
                        w_refresh    = 1'b1;
                    end
                end
                MODE_RED_JUMP_OFF: begin
                    // brightness output keeps its last value
                    n_red_level = r_red_off_level;
                    n_pix_color = COLOR_OFF;
                    w_refresh   = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // result beat built from the stepped state
    always_comb begin
        n_out                  = r_out;
        n_out.white_led_level  = n_white_out;
        n_out.pixel_color      = n_pix_color;
        n_out.pixel_brightness = n_pix_bright;
        n_out.pixel_refresh    = w_refresh;
        // jump off is reported as jump down
        n_out.active_mode      = (n_mode == MODE_RED_JUMP_OFF) ? MODE_RED_JUMP_DOWN : n_mode;
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_mode        <= MODE_ALL_OFF;
            r_white_level <= 8'd0;
            r_red_level   <= 8'd0;
            r_red_target  <= 8'd0;
            r_red_reached <= 1'b0;
            r_white_out   <= 8'd0;
            r_pix_color   <= COLOR_OFF;
            r_pix_bright  <= 8'd0;
            for (int i = 0; i < TMR_NUM; i++) begin
                r_elapsed[i] <= '0;
            end
        end else begin
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end

            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            r_mode        <= n_mode;
            r_white_level <= n_white_level;
            r_red_level   <= n_red_level;
            r_red_target  <= n_red_target;
            r_red_reached <= n_red_reached;
            r_white_out   <= n_white_out;
            r_pix_color   <= n_pix_color;
            r_pix_bright  <= n_pix_bright;
            for (int i = 0; i < TMR_NUM; i++) begin
                r_elapsed[i] <= n_elapsed[i];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in <= i_in_data;
        end
        if (w_fire) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// self-checking testbench for door_ambient_led_fader: a behavioral model of the fader
// predicts every result beat, and a checker compares them as they come out
// depends on dalf_pkg and the door_ambient_led_fader rtl
`default_nettype none

module tb;
    import dalf_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 4;     // settle margin after the last result
    localparam int REPORT_LIMIT = 10;
    localparam int RESET_CYCLES = 11;

    // settings as the fader sees them
    typedef struct packed {
        logic [15:0] white_step;
        logic [15:0] red_step;
        logic [7:0]  white_top;
        logic [7:0]  white_floor;
        logic [7:0]  red_on_min;
        logic [7:0]  red_off;
    } t_fader_settings;

    // dut ports
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;

    // idling knobs, percent of cycles
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;

    // bookkeeping
    int sent_ticks      = 0;
    int checked_results = 0;
    int mismatch_count  = 0;

    // results predicted for accepted ticks, oldest first
    t_out_item fader_results_due[$];

    // model copy of the register file, reset values
    t_fader_settings settings = '{
        white_step: 16'd4, red_step: 16'd8, white_top: 8'd255,
        white_floor: 8'd0, red_on_min: 8'd1, red_off: 8'd0
    };

    // model copy of the fader state, reset values
    t_mode                     fader_mode     = MODE_ALL_OFF;
    logic [7:0]                white_now      = '0;
    logic [7:0]                red_now        = '0;
    logic [7:0]                red_goal       = '0;
    logic                      red_at_goal    = 1'b0;
    logic [TIMER_BITS_DEF-1:0] elapsed_ms [TMR_NUM] = '{default: '0};
    logic [7:0]                white_drive    = '0;
    t_color                    pix_color_now  = COLOR_OFF;
    logic [7:0]                pix_bright_now = '0;

    door_ambient_led_fader dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // fader model
    // ------------------------------------------------------------------

    // a ramp may step once its elapsed counter has reached the step interval
    function automatic bit step_due(input int slot, input logic [15:0] interval);
        if (elapsed_ms[slot] >= interval) begin
            elapsed_ms[slot] = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // one millisecond tick: grow counters, pick the mode, then run it
    function automatic t_out_item fade_tick(input t_in_item beat);
        t_out_item res;
        logic      refresh;
        refresh = 1'b0;

        // free-running counters stick at all ones
        for (int k = 0; k < TMR_NUM; k++) begin
            if (elapsed_ms[k] != '1) elapsed_ms[k]++;
        end

        // mode choice; an unmatched branch keeps the previous mode
        if (!beat.door_open && beat.light_level == 8'd0 &&
            white_now == settings.white_floor && red_now == settings.red_off) begin
            fader_mode = MODE_ALL_OFF;
        end else if (beat.door_open) begin
            if (red_now > settings.red_off)
                fader_mode = MODE_RED_JUMP_OFF;
            else if (white_now < settings.white_top)
                fader_mode = MODE_WHITE_UP;
        end else begin
            red_goal = beat.light_level;
            if (white_now > settings.white_floor) begin
                fader_mode = MODE_WHITE_DOWN;
            end else if (red_goal >= settings.red_on_min) begin
                // a goal once reached makes later rises jump instead of ramp
                if (red_now < red_goal)
                    fader_mode = red_at_goal ? MODE_RED_JUMP_UP : MODE_RED_UP;
                else if (red_now > red_goal)
                    fader_mode = MODE_RED_JUMP_DOWN;
            end else if (red_goal == 8'd0 && red_now > settings.red_off) begin
                fader_mode = MODE_RED_DOWN;
            end
        end

        // mode step
        case (fader_mode)
            MODE_ALL_OFF: begin
                white_now = '0;
                red_now   = '0;
            end
            MODE_WHITE_UP: begin
                if (step_due(TMR_WHITE_UP, settings.white_step)) begin
                    if (white_now < settings.white_top) white_now++;
                    red_at_goal    = 1'b0;
                    pix_color_now  = COLOR_WHITE;
                    pix_bright_now = white_now;
                    white_drive    = white_now;
                    refresh        = 1'b1;
                end
            end
            MODE_WHITE_DOWN: begin
                if (step_due(TMR_WHITE_DOWN, settings.white_step)) begin
                    if (white_now > settings.white_floor) white_now--;
                    pix_color_now  = COLOR_WHITE;
                    pix_bright_now = white_now;
                    white_drive    = white_now;
                    refresh        = 1'b1;
                end
            end
            MODE_RED_UP: begin
                if (step_due(TMR_RED_UP, settings.red_step)) begin
                    if (red_now < red_goal) begin
                        red_now++;
                        if (red_now == red_goal) red_at_goal = 1'b1;
                    end
                    pix_color_now  = COLOR_RED;
                    pix_bright_now = red_now;
                    refresh        = 1'b1;
                end
            end
            MODE_RED_DOWN: begin
                if (step_due(TMR_RED_DOWN, settings.red_step)) begin
                    if (red_now > settings.red_off) begin
                        red_now--;
                        if (red_now == settings.red_off) red_at_goal = 1'b0;
                    end
                    pix_color_now  = COLOR_RED;
                    pix_bright_now = red_now;
                    refresh        = 1'b1;
                end
            end
            MODE_RED_JUMP_UP, MODE_RED_JUMP_DOWN: begin
                if ((fader_mode == MODE_RED_JUMP_UP) ? (red_now < red_goal)
                                                     : (red_now > red_goal)) begin
                    red_now        = red_goal;
                    pix_color_now  = COLOR_RED;
                    pix_bright_now = red_now;
                    refresh        = 1'b1;
                end
            end
            default: begin
                // jump off: brightness output keeps its old value
                red_now       = settings.red_off;
                pix_color_now = COLOR_OFF;
                refresh       = 1'b1;
            end
        endcase

        res.white_led_level  = white_drive;
        res.pixel_color      = pix_color_now;
        res.pixel_brightness = pix_bright_now;
        res.pixel_refresh    = refresh;
        // jump off is reported with the jump down code
        res.active_mode      = (fader_mode == MODE_RED_JUMP_OFF) ? MODE_RED_JUMP_DOWN
                                                                 : fader_mode;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // writes every register in turn; only called with the input channel idle
    task automatic load_settings(input t_fader_settings s);
        logic [CFG_IDX_W-1:0] idx;
        settings = s;
        for (int k = CFG_WHITE_STEP_MS; k <= CFG_RED_OFF_LEVEL; k++) begin
            idx = k[CFG_IDX_W-1:0];
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= idx;
            case (idx)
                CFG_WHITE_STEP_MS: i_cfg_data <= s.white_step;
                CFG_RED_STEP_MS:   i_cfg_data <= s.red_step;
                CFG_WHITE_MAX:     i_cfg_data <= {8'd0, s.white_top};
                CFG_WHITE_MIN:     i_cfg_data <= {8'd0, s.white_floor};
                CFG_RED_MIN:       i_cfg_data <= {8'd0, s.red_on_min};
                default:           i_cfg_data <= {8'd0, s.red_off};
            endcase
            @(posedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    // sends one tick beat, with random idle cycles ahead of it
    task automatic send_tick(input logic door, input logic [7:0] level);
        t_in_item beat;
        beat.door_open   = door;
        beat.light_level = level;
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        fader_results_due.push_back(fade_tick(beat));
        sent_ticks++;
        // payload holds until the edge that takes it
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // drop valid, let every predicted result arrive, then let the pipe settle
    task automatic wait_for_idle();
        i_in_valid <= 1'b0;
        while (fader_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // receiver stall, redrawn every cycle
    always @(posedge i_clk) begin
        i_out_stall <= (rx_stall_pct != 0) && ($urandom_range(0, 99) < rx_stall_pct);
    end

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (fader_results_due.size() == 0) begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("unexpected beat: w=%0d c=%0d b=%0d r=%0d m=%0d",
                             o_out_data.white_led_level, o_out_data.pixel_color,
                             o_out_data.pixel_brightness, o_out_data.pixel_refresh,
                             o_out_data.active_mode);
                mismatch_count++;
            end else begin
                want = fader_results_due.pop_front();
                checked_results++;
                if (o_out_data.white_led_level  !== want.white_led_level  ||
                    o_out_data.pixel_color      !== want.pixel_color      ||
                    o_out_data.pixel_brightness !== want.pixel_brightness ||
                    o_out_data.pixel_refresh    !== want.pixel_refresh    ||
                    o_out_data.active_mode      !== want.active_mode) begin
                    if (mismatch_count < REPORT_LIMIT) begin
                        $display("mismatch on result %0d", checked_results);
                        $display("  expected w=%0d c=%0d b=%0d r=%0d m=%0d",
                                 want.white_led_level, want.pixel_color,
                                 want.pixel_brightness, want.pixel_refresh,
                                 want.active_mode);
                        $display("  actual   w=%0d c=%0d b=%0d r=%0d m=%0d",
                                 o_out_data.white_led_level, o_out_data.pixel_color,
                                 o_out_data.pixel_brightness, o_out_data.pixel_refresh,
                                 o_out_data.active_mode);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // random choices
    // ------------------------------------------------------------------

    // mostly fast ramps, now and then one that never steps within a run
    function automatic logic [15:0] pick_step();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 16'd0;
            4, 5, 6:    return 16'd1;
            7:          return 16'd2;
            8:          return 16'($urandom_range(3, 6));
            default:    return 16'hFFFF;
        endcase
    endfunction

    // settings with extremes and odd orderings (floor above top, zero red threshold)
    function automatic t_fader_settings random_settings();
        t_fader_settings s;
        s.white_step = pick_step();
        s.red_step   = pick_step();
        case ($urandom_range(0, 4))
            0:       s.white_top = 8'd255;
            1:       s.white_top = 8'd0;
            default: s.white_top = 8'($urandom_range(1, 48));
        endcase
        case ($urandom_range(0, 3))
            0, 1:    s.white_floor = 8'd0;
            2:       s.white_floor = 8'($urandom_range(0, 16));
            default: s.white_floor = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 4))
            0:       s.red_on_min = 8'd0;
            1:       s.red_on_min = 8'd1;
            2:       s.red_on_min = 8'd255;
            default: s.red_on_min = 8'($urandom_range(1, 60));
        endcase
        case ($urandom_range(0, 9))
            0:       s.red_off = 8'd255;
            1, 2:    s.red_off = 8'($urandom_range(1, 20));
            default: s.red_off = 8'd0;
        endcase
        return s;
    endfunction

    // requests that hit off, the red threshold, just below it and full scale
    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 7))
            0, 1:    return 8'd0;
            2:       return settings.red_on_min;
            3:       return 8'd255;
            4:       return settings.red_on_min - 8'd1;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // walks through every mode with short ramps
    task automatic test_mode_walk();
        wait_for_idle();
        load_settings('{white_step: 16'd0, red_step: 16'd0, white_top: 8'd3,
                        white_floor: 8'd0, red_on_min: 8'd2, red_off: 8'd0});
        // door open: white ramps to its top and holds there
        repeat (4) send_tick(1'b1, 8'd255);
        // door closed: white ramps down, then red ramps to the request
        repeat (5) send_tick(1'b0, 8'd2);
        send_tick(1'b0, 8'd255);   // rise after goal reached: jump up
        send_tick(1'b0, 8'd128);   // jump down
        send_tick(1'b0, 8'd1);     // request under the red threshold
        repeat (3) send_tick(1'b0, 8'd0);  // fade red out, then all off
        repeat (2) send_tick(1'b0, 8'd3);  // slow red ramp again
        repeat (2) send_tick(1'b1, 8'd0);  // door opens with red lit: red off at once
    endtask

    // registers at both ends of their ranges
    task automatic test_register_extremes();
        wait_for_idle();
        // steps never due here, floor above top, red threshold of zero
        load_settings('{white_step: 16'hFFFF, red_step: 16'hFFFF, white_top: 8'd0,
                        white_floor: 8'd255, red_on_min: 8'd0, red_off: 8'd255});
        send_tick(1'b0, 8'd0);
        send_tick(1'b0, 8'd255);
        send_tick(1'b1, 8'd0);
        send_tick(1'b1, 8'd170);
        send_tick(1'b0, 8'd85);
        wait_for_idle();
        // steps every tick, full white range, only full scale lights red
        load_settings('{white_step: 16'd0, red_step: 16'd0, white_top: 8'd255,
                        white_floor: 8'd0, red_on_min: 8'd255, red_off: 8'd0});
        repeat (2) send_tick(1'b1, 8'd0);
        repeat (2) send_tick(1'b0, 8'd254);
        repeat (2) send_tick(1'b0, 8'd255);
    endtask

    // door episodes with random content, plus stray and broken ticks
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_ticks);
        int         sent;
        int         run_len;
        logic       door;
        logic [7:0] level;
        for (int round = 0; round < 2; round++) begin
            wait_for_idle();
            load_settings(random_settings());
            tx_idle_pct  = idle_pct;
            rx_stall_pct = stall_pct;
            sent = 0;
            while (sent < n_ticks / 2) begin
                if ($urandom_range(0, 99) < 12) begin
                    send_tick(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                    sent++;
                end else begin
                    door    = 1'($urandom_range(0, 1));
                    run_len = $urandom_range(1, 40);
                    level   = pick_level();
                    repeat (run_len) begin
                        // now and then the request changes mid-episode
                        if ($urandom_range(0, 9) == 0) level = pick_level();
                        send_tick(door, level);
                        sent++;
                    end
                end
            end
        end
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
    endtask

    // intervals of several ticks: counters run free between steps and clear on a step
    task automatic test_long_intervals();
        t_fader_settings s;
        s = '{white_step: 16'd5, red_step: 16'd7, white_top: 8'd6,
              white_floor: 8'd0, red_on_min: 8'd1, red_off: 8'd0};
        wait_for_idle();
        load_settings(s);
        repeat (25) send_tick(1'b0, 8'd0);   // fade out whatever is lit
        repeat (30) send_tick(1'b1, 8'd0);   // door open: slow white ramp up
        repeat (30) send_tick(1'b0, 8'd4);   // white down, then slow red ramp
        repeat (5) send_tick(1'b0, 8'd0);    // red starts to fade
    endtask

    // ------------------------------------------------------------------
    // run
    // ------------------------------------------------------------------

    // watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results still due",
                 CYCLE_LIMIT, fader_results_due.size());
        $display("status: fail");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_mode_walk();
        test_register_extremes();
        test_random_traffic(0, 0, 110);     // back to back
        test_random_traffic(85, 0, 110);    // sparse sender
        test_random_traffic(0, 85, 110);    // slow receiver
        test_random_traffic(20, 20, 110);   // both idling
        test_long_intervals();
        wait_for_idle();

        $display("ran %0d tick beats: mode walk, register extremes, four idling mixes",
                 sent_ticks);
        $display("and multi-tick ramp intervals; %0d results checked, %0d mismatches",
                 checked_results, mismatch_count);
        if (mismatch_count == 0 && fader_results_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
